FILE: hw/rtl/tpca_pkg.sv
// ----------------------------------------------------------------------------
// tpca_pkg
// Shared types and constants of the touch point calibration and averaging
// block.
// ----------------------------------------------------------------------------
package tpca_pkg;

    localparam int COORD_W       = 12;
    localparam int PROD_W        = 2 * COORD_W;
    localparam int MIRROR_W      = COORD_W + 2;
    localparam int CNT_W         = 5;
    localparam int ORIENT_W      = 3;
    localparam int CFG_IDX_W     = 3;
    localparam int AVG_DEPTH_DEF = 4;

    localparam logic [COORD_W-1:0]  COORD_MAX     = 12'd4095;
    localparam logic [MIRROR_W-1:0] MIRROR_OFFSET = 14'd20;

    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SPAN_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SPAN_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_MODE    = 3'd6;

    localparam int ORIENT_SWAP  = 0;
    localparam int ORIENT_INV_X = 1;
    localparam int ORIENT_INV_Y = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX_SETUP,
        ST_MUL,
        ST_DIV,
        ST_AX_POST,
        ST_PUSH,
        ST_SUM,
        ST_AVG_SETUP,
        ST_AVG_DIV,
        ST_AVG_POST,
        ST_DONE
    } t_state;

endpackage

FILE: hw/rtl/touch_point_calibrate_average_top.sv
// ----------------------------------------------------------------------------
// touch_point_calibrate_average_top
// Mirrors, swaps, offsets, scales and inverts a raw touch point, then averages
// it over the recent history of pressed points.
// ----------------------------------------------------------------------------
// One sample is taken at a time. A released or invalid sample goes straight
// to the done state. A valid pressed sample is calibrated axis by axis, pushed
// into the history, summed over the history count after the push and then
// averaged per axis, with SUM_W = 12 + clog2(AVG_DEPTH). The work is done by
// one shared shift-add multiplier and one restoring divider that handle one
// bit per cycle: 12 multiply and 24 divide steps per axis, then SUM_W divide
// steps for each averaged axis.
// A finished result waits in the output register while the next sample is
// accepted.
module touch_point_calibrate_average_top #(
    parameter int AVG_DEPTH = tpca_pkg::AVG_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tpca_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpca_pkg::COORD_W-1:0]     i_cfg_data,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_touch_line_active,
    input  logic                             i_point_valid,
    input  logic [tpca_pkg::COORD_W-1:0]     i_raw_x,
    input  logic [tpca_pkg::COORD_W-1:0]     i_raw_y,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_pressed,
    output logic [tpca_pkg::COORD_W-1:0]     o_point_x,
    output logic [tpca_pkg::COORD_W-1:0]     o_point_y
);

    localparam int CW     = tpca_pkg::COORD_W;
    localparam int PW     = tpca_pkg::PROD_W;
    localparam int MW     = tpca_pkg::MIRROR_W;
    localparam int NW     = tpca_pkg::CNT_W;
    localparam int FILL_W = $clog2(AVG_DEPTH + 1);
    localparam int IDX_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W  = CW + $clog2(AVG_DEPTH);

    // configuration
    logic [CW-1:0]                 r_width;
    logic [CW-1:0]                 r_height;
    logic [CW-1:0]                 r_x_lo;
    logic [CW-1:0]                 r_x_hi;
    logic [CW-1:0]                 r_y_lo;
    logic [CW-1:0]                 r_y_hi;
    logic [tpca_pkg::ORIENT_W-1:0] r_orient;

    // sequencer and datapath
    tpca_pkg::t_state    r_state;
    tpca_pkg::t_state    n_state;
    logic                r_axis;
    logic [NW-1:0]       r_cnt;
    logic signed [MW-1:0] r_vx;
    logic signed [MW-1:0] r_vy;
    logic [CW-1:0]       r_off;
    logic [CW-1:0]       r_mpl;
    logic [PW-1:0]       r_acc;
    logic [CW-1:0]       r_rem;
    logic [CW-1:0]       r_dvs;
    logic [CW-1:0]       r_cx;
    logic [CW-1:0]       r_cy;
    logic [SUM_W-1:0]    r_sx;
    logic [SUM_W-1:0]    r_sy;
    logic [CW-1:0]       r_hx [AVG_DEPTH];
    logic [CW-1:0]       r_hy [AVG_DEPTH];
    logic [FILL_W-1:0]   r_fill;
    logic [CW-1:0]       r_last_x;
    logic [CW-1:0]       r_last_y;
    logic                r_pend_pressed;

    // output register
    logic                r_out_valid;
    logic                r_out_pressed;
    logic [CW-1:0]       r_out_x;
    logic [CW-1:0]       r_out_y;

    logic                in_accept;
    logic                out_load;
    logic                cfg_write;

    logic signed [MW-1:0] mir_x;
    logic signed [MW-1:0] mir_y;
    logic signed [MW-1:0] ax_v;
    logic [CW-1:0]        ax_size;
    logic [CW-1:0]        ax_lo;
    logic [CW-1:0]        ax_hi;
    logic                 ax_inv;
    logic [CW-1:0]        ax_off;
    logic [CW-1:0]        ax_span;
    logic                 ax_span_ok;
    logic [CW-1:0]        ax_res;
    logic [PW-1:0]        mul_next;
    logic [CW:0]          div_shift;
    logic [CW:0]          div_diff;
    logic                 div_ge;
    logic [IDX_W-1:0]     sum_idx;
    logic                 sum_last;
    logic [SUM_W-1:0]     avg_sum;

    // ------------------------------------------------------------------
    // combinational datapath
    // ------------------------------------------------------------------
    always_comb begin
        mir_x = $signed({2'b00, r_width}) - $signed({2'b00, i_raw_x})
                - $signed(tpca_pkg::MIRROR_OFFSET);
        mir_y = $signed({2'b00, r_height}) - $signed({2'b00, i_raw_y})
                - $signed(tpca_pkg::MIRROR_OFFSET);

        ax_v    = r_axis ? r_vy : r_vx;
        ax_size = r_axis ? r_height : r_width;
        ax_lo   = r_axis ? r_y_lo : r_x_lo;
        ax_hi   = r_axis ? r_y_hi : r_x_hi;
        ax_inv  = r_axis ? r_orient[tpca_pkg::ORIENT_INV_Y] : r_orient[tpca_pkg::ORIENT_INV_X];

        if (ax_v > $signed({2'b00, ax_lo})) begin
            ax_off = CW'(ax_v - $signed({2'b00, ax_lo}));
        end else begin
            ax_off = '0;
        end
        ax_span_ok = ax_hi > ax_lo;
        ax_span    = ax_hi - ax_lo;

        if (ax_inv) begin
            if (r_acc > PW'(ax_size)) begin
                ax_res = '0;
            end else begin
                ax_res = ax_size - r_acc[CW-1:0];
            end
        end else if (r_acc > PW'(tpca_pkg::COORD_MAX)) begin
            ax_res = tpca_pkg::COORD_MAX;
        end else begin
            ax_res = r_acc[CW-1:0];
        end

        mul_next  = {r_acc[PW-2:0], 1'b0} + PW'(r_mpl[CW-1] ? r_off : '0);

        div_shift = {r_rem, r_acc[PW-1]};
        div_ge    = div_shift >= {1'b0, r_dvs};
        div_diff  = div_shift - {1'b0, r_dvs};

        sum_idx  = r_cnt[IDX_W-1:0];
        sum_last = (NW + 1)'(r_cnt) + 1'b1 == (NW + 1)'(r_fill);
        avg_sum  = r_axis ? r_sy : r_sx;
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tpca_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (i_touch_line_active && i_point_valid) begin
                        n_state = tpca_pkg::ST_AX_SETUP;
                    end else begin
                        n_state = tpca_pkg::ST_DONE;
                    end
                end
            end
            tpca_pkg::ST_AX_SETUP: begin
                n_state = ax_span_ok ? tpca_pkg::ST_MUL : tpca_pkg::ST_AX_POST;
            end
            tpca_pkg::ST_MUL: begin
                if (r_cnt == '0) n_state = tpca_pkg::ST_DIV;
            end
            tpca_pkg::ST_DIV: begin
                if (r_cnt == '0) n_state = tpca_pkg::ST_AX_POST;
            end
            tpca_pkg::ST_AX_POST: begin
                n_state = r_axis ? tpca_pkg::ST_PUSH : tpca_pkg::ST_AX_SETUP;
            end
            tpca_pkg::ST_PUSH: begin
                n_state = tpca_pkg::ST_SUM;
            end
            tpca_pkg::ST_SUM: begin
                if (sum_last) n_state = tpca_pkg::ST_AVG_SETUP;
            end
            tpca_pkg::ST_AVG_SETUP: begin
                n_state = tpca_pkg::ST_AVG_DIV;
            end
            tpca_pkg::ST_AVG_DIV: begin
                if (r_cnt == '0) n_state = tpca_pkg::ST_AVG_POST;
            end
            tpca_pkg::ST_AVG_POST: begin
                n_state = r_axis ? tpca_pkg::ST_DONE : tpca_pkg::ST_AVG_SETUP;
            end
            tpca_pkg::ST_DONE: begin
                if (out_load) n_state = tpca_pkg::ST_IDLE;
            end
            default: begin
                n_state = tpca_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // handshake outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_cfg_ready = 1'b1;
        cfg_write   = i_cfg_valid && o_cfg_ready;
        o_in_stall  = r_state != tpca_pkg::ST_IDLE;
        in_accept   = i_in_valid && !o_in_stall;
        out_load    = (r_state == tpca_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);
        o_out_valid = r_out_valid;
        o_pressed   = r_out_pressed;
        o_point_x   = r_out_x;
        o_point_y   = r_out_y;
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd320;
            r_height <= 12'd240;
            r_x_lo   <= 12'd0;
            r_x_hi   <= 12'd320;
            r_y_lo   <= 12'd0;
            r_y_hi   <= 12'd240;
            r_orient <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                tpca_pkg::CFG_DISPLAY_WIDTH:  r_width  <= i_cfg_data;
                tpca_pkg::CFG_DISPLAY_HEIGHT: r_height <= i_cfg_data;
                tpca_pkg::CFG_X_SPAN_LOW:     r_x_lo   <= i_cfg_data;
                tpca_pkg::CFG_X_SPAN_HIGH:    r_x_hi   <= i_cfg_data;
                tpca_pkg::CFG_Y_SPAN_LOW:     r_y_lo   <= i_cfg_data;
                tpca_pkg::CFG_Y_SPAN_HIGH:    r_y_hi   <= i_cfg_data;
                tpca_pkg::CFG_ORIENT_MODE:    r_orient <= i_cfg_data[tpca_pkg::ORIENT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tpca_pkg::ST_IDLE;
            r_fill         <= '0;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_pend_pressed <= 1'b0;
            r_axis         <= 1'b0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                tpca_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_axis <= 1'b0;
                        if (!i_touch_line_active) r_fill <= '0;
                        r_pend_pressed <= i_touch_line_active && i_point_valid;
                    end
                end
                tpca_pkg::ST_AX_SETUP: begin
                    r_cnt <= NW'(CW - 1);
                end
                tpca_pkg::ST_MUL: begin
                    r_cnt <= (r_cnt == '0) ? NW'(PW - 1) : r_cnt - 1'b1;
                end
                tpca_pkg::ST_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                tpca_pkg::ST_AX_POST: begin
                    r_axis <= !r_axis;
                end
                tpca_pkg::ST_PUSH: begin
                    r_cnt <= '0;
                    if (r_fill != FILL_W'(AVG_DEPTH)) r_fill <= r_fill + 1'b1;
                end
                tpca_pkg::ST_SUM: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_axis <= 1'b0;
                end
                tpca_pkg::ST_AVG_SETUP: begin
                    r_cnt <= NW'(SUM_W - 1);
                end
                tpca_pkg::ST_AVG_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                tpca_pkg::ST_AVG_POST: begin
                    r_axis <= !r_axis;
                    if (r_axis) begin
                        r_last_y <= r_acc[CW-1:0];
                    end else begin
                        r_last_x <= r_acc[CW-1:0];
                    end
                end
                tpca_pkg::ST_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pressed <= r_pend_pressed;
            r_out_x       <= r_last_x;
            r_out_y       <= r_last_y;
        end

        unique case (r_state)
            tpca_pkg::ST_IDLE: begin
                if (r_orient[tpca_pkg::ORIENT_SWAP]) begin
                    r_vx <= mir_y;
                    r_vy <= mir_x;
                end else begin
                    r_vx <= mir_x;
                    r_vy <= mir_y;
                end
            end
            tpca_pkg::ST_AX_SETUP: begin
                r_off <= ax_off;
                r_mpl <= ax_size;
                r_acc <= '0;
                r_dvs <= ax_span;
                r_rem <= '0;
            end
            tpca_pkg::ST_MUL: begin
                r_acc <= mul_next;
                r_mpl <= {r_mpl[CW-2:0], 1'b0};
            end
            tpca_pkg::ST_DIV, tpca_pkg::ST_AVG_DIV: begin
                r_acc <= {r_acc[PW-2:0], div_ge};
                r_rem <= div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
            end
            tpca_pkg::ST_AX_POST: begin
                if (r_axis) begin
                    r_cy <= ax_res;
                end else begin
                    r_cx <= ax_res;
                end
            end
            tpca_pkg::ST_PUSH: begin
                for (int i = AVG_DEPTH - 1; i > 0; i--) begin
                    r_hx[i] <= r_hx[i-1];
                    r_hy[i] <= r_hy[i-1];
                end
                r_hx[0] <= r_cx;
                r_hy[0] <= r_cy;
                r_sx    <= '0;
                r_sy    <= '0;
            end
            tpca_pkg::ST_SUM: begin
                r_sx <= r_sx + SUM_W'(r_hx[sum_idx]);
                r_sy <= r_sy + SUM_W'(r_hy[sum_idx]);
            end
            tpca_pkg::ST_AVG_SETUP: begin
                r_acc <= PW'(avg_sum) << (PW - SUM_W);
                r_dvs <= CW'(r_fill);
                r_rem <= '0;
            end
            tpca_pkg::ST_AVG_POST, tpca_pkg::ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(AVG_DEPTH))
        else $error("history count above depth");

    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && !i_touch_line_active |=> r_fill == '0)
        else $error("released line did not clear history count");

    a_point_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_touch_line_active && i_point_valid
        |=> r_state == tpca_pkg::ST_AX_SETUP && r_pend_pressed)
        else $error("valid point did not start calibration");

    a_sum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpca_pkg::ST_SUM |-> (NW + 1)'(r_cnt) < (NW + 1)'(r_fill))
        else $error("sum index beyond history count");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tpca_pkg::ST_DONE && n_state == tpca_pkg::ST_IDLE |=> r_out_valid)
        else $error("finished result not loaded");
`endif

endmodule
